### sv/sid_pkg.sv
`default_nettype none

package sid_pkg;

    // Field widths
    localparam int COORD_W     = 16;
    localparam int FRAC_BITS   = 16;
    localparam int OFFSET_BITS = 16;
    localparam int POINT_W     = 32;
    localparam int OFF_W       = OFFSET_BITS + 1;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;
    localparam int DEN_W  = DET_W;
    localparam int MUL_W  = DEN_W + 1 + DIFF_W;
    localparam int MAG_W  = MUL_W - 1;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int Q_W    = DIFF_W + FRAC_BITS + 1;

    // Divider lanes
    localparam int LANES    = 3;
    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;
    localparam int LANE_OFF = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [DET_W-1:0]   det_t;

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_CROSS   = 2'd1,
        CLS_OVERLAP = 2'd2,
        CLS_DEGEN   = 2'd3
    } hit_class_t;

    typedef struct packed {
        hit_class_t cls;
        logic       neg_x;
        logic       neg_y;
        coord_t     ax;
        coord_t     ay;
        coord_t     px;
        coord_t     py;
    } side_t;

    typedef struct packed {
        logic                          valid;
        logic [LANES-1:0][NUM_W-1:0]   num;
        logic [LANES-1:0][DEN_W-1:0]   den;
        side_t                         side;
    } div_req_t;

    typedef struct packed {
        logic                          valid;
        logic [LANES-1:0][Q_W-1:0]     q;
        logic [LANES-1:0]              rem_nz;
        side_t                         side;
    } div_rsp_t;

endpackage

`default_nettype wire

### sv/sid_pair_if.sv
`default_nettype none

interface sid_pair_if import sid_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

`default_nettype wire

### sv/sid_hit_if.sv
`default_nettype none

interface sid_hit_if import sid_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                hit_class;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [OFF_W-1:0]          offset_along;

    modport source (output valid, hit_class, point_x, point_y, offset_along, input ready);
    modport sink   (input valid, hit_class, point_x, point_y, offset_along, output ready);
endinterface

`default_nettype wire

### sv/sid_front.sv
`default_nettype none

module sid_front import sid_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    sid_pair_if.sink       pair,
    output div_req_t       req
);

    function automatic logic lex_lt(coord_t px, coord_t py, coord_t qx, coord_t qy);
        return (px < qx) || ((px == qx) && (py < qy));
    endfunction

    function automatic logic span_meet(coord_t a, coord_t b, coord_t c, coord_t d);
        coord_t lo_ab;
        coord_t hi_ab;
        coord_t lo_cd;
        coord_t hi_cd;
        coord_t lo;
        coord_t hi;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a > b) ? a : b;
        lo_cd = (c < d) ? c : d;
        hi_cd = (c > d) ? c : d;
        lo    = (lo_ab > lo_cd) ? lo_ab : lo_cd;
        hi    = (hi_ab < hi_cd) ? hi_ab : hi_cd;
        return lo <= hi;
    endfunction

    function automatic diff_t sub_c(coord_t p, coord_t q);
        return $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    endfunction

    assign pair.ready = en;

    // ---------------- stage 1: differences, box test, overlap end point
    logic   v1_reg;
    diff_t  rx1_reg, ry1_reg, sx1_reg, sy1_reg, qx1_reg, qy1_reg, pdx1_reg, pdy1_reg;
    coord_t ax1_reg, ay1_reg, px1_reg, py1_reg;
    logic   rej1_reg, deg1_reg;

    coord_t hx, hy, ux, uy, px_next, py_next;
    logic   rej_next, deg_next;

    always_comb
    begin
        hx = pair.b_x;
        hy = pair.b_y;
        if (lex_lt(pair.b_x, pair.b_y, pair.a_x, pair.a_y))
        begin
            hx = pair.a_x;
            hy = pair.a_y;
        end
        ux = pair.d_x;
        uy = pair.d_y;
        if (lex_lt(pair.d_x, pair.d_y, pair.c_x, pair.c_y))
        begin
            ux = pair.c_x;
            uy = pair.c_y;
        end
        px_next = hx;
        py_next = hy;
        if (lex_lt(ux, uy, hx, hy))
        begin
            px_next = ux;
            py_next = uy;
        end
        rej_next = !span_meet(pair.a_x, pair.b_x, pair.c_x, pair.d_x)
                || !span_meet(pair.a_y, pair.b_y, pair.c_y, pair.d_y);
        deg_next = ((pair.a_x == pair.b_x) && (pair.a_y == pair.b_y))
                || ((pair.c_x == pair.d_x) && (pair.c_y == pair.d_y));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx1_reg  <= sub_c(pair.b_x, pair.a_x);
            ry1_reg  <= sub_c(pair.b_y, pair.a_y);
            sx1_reg  <= sub_c(pair.d_x, pair.c_x);
            sy1_reg  <= sub_c(pair.d_y, pair.c_y);
            qx1_reg  <= sub_c(pair.c_x, pair.a_x);
            qy1_reg  <= sub_c(pair.c_y, pair.a_y);
            pdx1_reg <= sub_c(px_next, pair.a_x);
            pdy1_reg <= sub_c(py_next, pair.a_y);
            ax1_reg  <= pair.a_x;
            ay1_reg  <= pair.a_y;
            px1_reg  <= px_next;
            py1_reg  <= py_next;
            rej1_reg <= rej_next;
            deg1_reg <= deg_next;
        end
    end

    // ---------------- stage 2: cross and dot products
    logic   v2_reg;
    det_t   den2_reg, tn2_reg, un2_reg, dt2_reg, len2_reg;
    diff_t  rx2_reg, ry2_reg;
    coord_t ax2_reg, ay2_reg, px2_reg, py2_reg;
    logic   rej2_reg, deg2_reg;

    det_t den_next, tn_next, un_next, dt_next, len_next;

    always_comb
    begin
        den_next = DET_W'(rx1_reg * sy1_reg) - DET_W'(ry1_reg * sx1_reg);
        tn_next  = DET_W'(qx1_reg * sy1_reg) - DET_W'(qy1_reg * sx1_reg);
        un_next  = DET_W'(qx1_reg * ry1_reg) - DET_W'(qy1_reg * rx1_reg);
        dt_next  = DET_W'(pdx1_reg * rx1_reg) + DET_W'(pdy1_reg * ry1_reg);
        len_next = DET_W'(rx1_reg * rx1_reg) + DET_W'(ry1_reg * ry1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den2_reg <= den_next;
            tn2_reg  <= tn_next;
            un2_reg  <= un_next;
            dt2_reg  <= dt_next;
            len2_reg <= len_next;
            rx2_reg  <= rx1_reg;
            ry2_reg  <= ry1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            rej2_reg <= rej1_reg;
            deg2_reg <= deg1_reg;
        end
    end

    // ---------------- stage 3: classify, fold signs, pick offset operands
    logic             v3_reg;
    hit_class_t       cls3_reg;
    logic [DEN_W-1:0] tabs3_reg, dabs3_reg, offn3_reg, offd3_reg;
    diff_t            rx3_reg, ry3_reg;
    coord_t           ax3_reg, ay3_reg, px3_reg, py3_reg;

    hit_class_t       cls_next;
    logic [DEN_W-1:0] tabs_next, dabs_next, offn_next, offd_next;
    logic             den_neg, in_range;

    always_comb
    begin
        den_neg   = den2_reg < 0;
        dabs_next = den_neg ? DEN_W'(-den2_reg) : DEN_W'(den2_reg);
        tabs_next = den_neg ? DEN_W'(-tn2_reg) : DEN_W'(tn2_reg);
        if (den_neg)
        begin
            in_range = (tn2_reg <= 0) && (tn2_reg >= den2_reg)
                    && (un2_reg <= 0) && (un2_reg >= den2_reg);
        end
        else
        begin
            in_range = (tn2_reg >= 0) && (tn2_reg <= den2_reg)
                    && (un2_reg >= 0) && (un2_reg <= den2_reg);
        end

        priority if (rej2_reg)
            cls_next = CLS_NONE;
        else if (deg2_reg)
            cls_next = CLS_DEGEN;
        else if (den2_reg == 0)
            cls_next = (un2_reg != 0) ? CLS_NONE : CLS_OVERLAP;
        else
            cls_next = in_range ? CLS_CROSS : CLS_NONE;

        if (cls_next == CLS_OVERLAP)
        begin
            offd_next = DEN_W'(len2_reg);
            priority if (dt2_reg < 0)
                offn_next = '0;
            else if (dt2_reg > len2_reg)
                offn_next = DEN_W'(len2_reg);
            else
                offn_next = DEN_W'(dt2_reg);
        end
        else
        begin
            offd_next = dabs_next;
            offn_next = tabs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls3_reg  <= cls_next;
            tabs3_reg <= tabs_next;
            dabs3_reg <= dabs_next;
            offn3_reg <= offn_next;
            offd3_reg <= offd_next;
            rx3_reg   <= rx2_reg;
            ry3_reg   <= ry2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
        end
    end

    // ---------------- stage 4: scale AB by the crossing parameter numerator
    logic                    v4_reg;
    hit_class_t              cls4_reg;
    logic signed [MUL_W-1:0] mx4_reg, my4_reg;
    logic [DEN_W-1:0]        dabs4_reg, offn4_reg, offd4_reg;
    coord_t                  ax4_reg, ay4_reg, px4_reg, py4_reg;

    logic signed [DEN_W:0] tabs_s;

    assign tabs_s = $signed({1'b0, tabs3_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx4_reg   <= MUL_W'(tabs_s * rx3_reg);
            my4_reg   <= MUL_W'(tabs_s * ry3_reg);
            cls4_reg  <= cls3_reg;
            dabs4_reg <= dabs3_reg;
            offn4_reg <= offn3_reg;
            offd4_reg <= offd3_reg;
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            px4_reg   <= px3_reg;
            py4_reg   <= py3_reg;
        end
    end

    // ---------------- stage 5: magnitudes and divider operands
    div_req_t         req_reg;
    div_req_t         req_next;
    logic [MAG_W-1:0] magx, magy;

    always_comb
    begin
        magx = (mx4_reg < 0) ? MAG_W'(-mx4_reg) : MAG_W'(mx4_reg);
        magy = (my4_reg < 0) ? MAG_W'(-my4_reg) : MAG_W'(my4_reg);
        req_next.valid          = v4_reg;
        req_next.num[LANE_X]    = {magx, {FRAC_BITS{1'b0}}};
        req_next.num[LANE_Y]    = {magy, {FRAC_BITS{1'b0}}};
        req_next.num[LANE_OFF]  = NUM_W'({offn4_reg, {OFFSET_BITS{1'b0}}});
        req_next.den[LANE_X]    = dabs4_reg;
        req_next.den[LANE_Y]    = dabs4_reg;
        req_next.den[LANE_OFF]  = offd4_reg;
        req_next.side.cls       = cls4_reg;
        req_next.side.neg_x     = mx4_reg < 0;
        req_next.side.neg_y     = my4_reg < 0;
        req_next.side.ax        = ax4_reg;
        req_next.side.ay        = ay4_reg;
        req_next.side.px        = px4_reg;
        req_next.side.py        = py4_reg;
    end

    // the valid bit rides in this register, so clear it on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
        end
        else if (en)
        begin
            req_reg <= req_next;
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pair.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        req       = req_reg;
        req.valid = req_reg.valid;
    end

endmodule

`default_nettype wire

### sv/sid_div.sv
`default_nettype none

module sid_div import sid_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire div_req_t  req,
    output div_rsp_t       rsp
);

    // one restoring step per stage; the low word shifts numerator bits out
    // at the top and quotient bits in at the bottom
    logic [LANES-1:0][DEN_W-1:0] rem_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]   lq_reg  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] den_reg [Q_W];
    side_t                       side_reg [Q_W];
    logic [Q_W-1:0]              vld_reg;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] rem_in, rem_next, den_in;
        logic [LANES-1:0][Q_W-1:0]   lq_in, lq_next;
        side_t                       side_in;
        logic                        vld_in;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = DEN_W'(req.num[l] >> Q_W);
                    lq_in[l]  = req.num[l][Q_W-1:0];
                end
            end
            assign den_in  = req.den;
            assign side_in = req.side;
            assign vld_in  = req.valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign lq_in   = lq_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            logic [DEN_W:0] trial;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial       = {rem_in[l], lq_in[l][Q_W-1]};
                ge          = trial >= {1'b0, den_in[l]};
                rem_next[l] = ge ? DEN_W'(trial - {1'b0, den_in[l]}) : DEN_W'(trial);
                lq_next[l]  = {lq_in[l][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                lq_reg[k]   <= lq_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb
    begin
        rsp.valid = vld_reg[Q_W-1];
        rsp.side  = side_reg[Q_W-1];
        for (int l = 0; l < LANES; l++)
        begin
            rsp.q[l]      = lq_reg[Q_W-1][l];
            rsp.rem_nz[l] = |rem_reg[Q_W-1][l];
        end
    end

endmodule

`default_nettype wire

### sv/sid_back.sv
`default_nettype none

module sid_back import sid_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire div_rsp_t  rsp,
    sid_hit_if.source      hit
);

    logic                      vld_reg;
    hit_class_t                cls_reg;
    logic signed [POINT_W-1:0] px_reg, py_reg;
    logic [OFF_W-1:0]          off_reg;

    logic signed [POINT_W-1:0] px_next, py_next;
    logic [OFF_W-1:0]          off_next;
    logic [Q_W:0]              qx_s, qy_s;
    logic signed [Q_W:0]       sum_x, sum_y;

    // floor of a negative quotient: -q, one lower when the remainder is nonzero
    function automatic logic [Q_W:0] floor_q(logic [Q_W-1:0] q, logic neg, logic nz);
        logic [Q_W:0] qe;
        qe = {1'b0, q};
        if (!neg)
            return qe;
        return nz ? ~qe : (~qe + 1'b1);
    endfunction

    always_comb
    begin
        qx_s  = floor_q(rsp.q[LANE_X], rsp.side.neg_x, rsp.rem_nz[LANE_X]);
        qy_s  = floor_q(rsp.q[LANE_Y], rsp.side.neg_y, rsp.rem_nz[LANE_Y]);
        sum_x = (Q_W+1)'($signed({rsp.side.ax, {FRAC_BITS{1'b0}}})) + $signed(qx_s);
        sum_y = (Q_W+1)'($signed({rsp.side.ay, {FRAC_BITS{1'b0}}})) + $signed(qy_s);

        unique case (rsp.side.cls)
            CLS_CROSS:
            begin
                px_next  = sum_x[POINT_W-1:0];
                py_next  = sum_y[POINT_W-1:0];
                off_next = rsp.q[LANE_OFF][OFF_W-1:0];
            end
            CLS_OVERLAP:
            begin
                px_next  = POINT_W'($signed({rsp.side.px, {FRAC_BITS{1'b0}}}));
                py_next  = POINT_W'($signed({rsp.side.py, {FRAC_BITS{1'b0}}}));
                off_next = rsp.q[LANE_OFF][OFF_W-1:0];
            end
            default:
            begin
                px_next  = '0;
                py_next  = '0;
                off_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= rsp.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg <= rsp.side.cls;
            px_reg  <= px_next;
            py_reg  <= py_next;
            off_reg <= off_next;
        end
    end

    assign hit.valid        = vld_reg;
    assign hit.hit_class    = cls_reg;
    assign hit.point_x      = px_reg;
    assign hit.point_y      = py_reg;
    assign hit.offset_along = off_reg;

endmodule

`default_nettype wire

### sv/segment_intersection_2d.sv
// Pipeline: 5 front stages, 34 divider stages, 1 output register.
// Throughput: one request per cycle while the sink does not stall; the
//   34-stage long-division pipeline retires one quotient bit per stage
//   in each of its three lanes.
// Reset: rst_n clears all valid bits at once; no clearing pass is needed.
`default_nettype none

module segment_intersection_2d import sid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sid_pair_if.sink  pair,
    sid_hit_if.source hit
);

    // Single advance strobe for the whole pipe: move when the output
    // register is empty or being drained, otherwise hold every stage.
    logic     en;
    div_req_t req;
    div_rsp_t rsp;

    assign en = !hit.valid || hit.ready;

    // Front: differences, box rejection, cross products, classification,
    // parameter scaling and divider operand setup.
    sid_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .pair  (pair),
        .req   (req)
    );

    // Three-lane divider: x and y of the crossing point share the
    // denominator; the offset lane divides by den or by |AB|^2.
    sid_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (req),
        .rsp   (rsp)
    );

    // Back: floor signed quotients, add A for crossings, keep overlap
    // ends, zero misses and degenerates, hold the result for the sink.
    sid_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .rsp   (rsp),
        .hit   (hit)
    );

endmodule

`default_nettype wire

### sv/sid_checker.sv
`default_nettype none

module sid_checker import sid_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      hit_valid,
    input wire logic                      hit_ready,
    input wire logic [1:0]                hit_class,
    input wire logic signed [POINT_W-1:0] point_x,
    input wire logic signed [POINT_W-1:0] point_y,
    input wire logic [OFF_W-1:0]          offset_along
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> hit_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> $stable(point_x) && $stable(point_y)
                                    && $stable(offset_along) && $stable(hit_class))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && (hit_class == CLS_NONE || hit_class == CLS_DEGEN)
        |-> point_x == 0 && point_y == 0 && offset_along == 0)
        else $error("miss or degenerate result carries data");

    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> offset_along <= (OFF_W'(1) << OFFSET_BITS))
        else $error("offset beyond one");

    a_overlap_grid: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_class == CLS_OVERLAP
        |-> point_x[FRAC_BITS-1:0] == 0 && point_y[FRAC_BITS-1:0] == 0)
        else $error("overlap point off the integer grid");

endmodule

bind segment_intersection_2d sid_checker u_sid_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .hit_valid    (hit.valid),
    .hit_ready    (hit.ready),
    .hit_class    (hit.hit_class),
    .point_x      (hit.point_x),
    .point_y      (hit.point_y),
    .offset_along (hit.offset_along)
);

`default_nettype wire

### tb/sv/segment_intersection_2d_test.sv
`default_nettype none

module segment_intersection_2d_test import sid_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 40;
    localparam int RANDOM_REQS = 1100;
    localparam int HOLD_CYCLES = 200;
    localparam int WATCHDOG    = 5000;

    // One segment pair as it travels on the request channel.
    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    // One intersection result as it leaves the block.
    typedef struct {
        hit_class_t                cls;
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
        logic [OFF_W-1:0]          off;
    } hit_rec_t;

    // A directed row: the pair, and a typed-in result where one is obvious.
    typedef struct {
        seg_pair_t pair;
        bit        typed;
        hit_rec_t  want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sid_pair_if pair_ch ();
    sid_hit_if  hit_ch ();

    segment_intersection_2d u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pair  (pair_ch.sink),
        .hit   (hit_ch.source)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hit_rec_t pending_hits[$];
    hit_rec_t typed_hits[$];
    bit       typed_flags[$];
    dir_row_t table_rows[$];
    int       mismatches;
    int       idle_count;
    bit       sending_done;
    bit       quiet_phase;   // stretch with no idling on either side
    bit       hold_off;      // long receiver stall while sender keeps offering

    // ------------------------------------------------------------------
    // Predictor: exact integer geometry, floored fixed-point output.
    // ------------------------------------------------------------------
    function automatic longint floor_div(longint n, longint d, output longint r);
        longint q;
        q = n / d;
        r = n % d;
        if (r < 0)
        begin
            q = q - 1;
            r = r + d;
        end
        return q;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [31:0] lerp_point(longint a, longint dv, longint tn,
                                               longint den);
        longint q, r, f, r2;
        q = floor_div(tn * dv, den, r);
        f = floor_div(r * (64'sd1 <<< FRAC_BITS), den, r2);
        return clamp32((a + q) * (64'sd1 <<< FRAC_BITS) + f);
    endfunction

    function automatic bit spans_meet(longint a, longint b, longint c, longint d);
        longint lo1, hi1, lo2, hi2;
        lo1 = (a < b) ? a : b;
        hi1 = (a > b) ? a : b;
        lo2 = (c < d) ? c : d;
        hi2 = (c > d) ? c : d;
        return ((lo1 > lo2) ? lo1 : lo2) <= ((hi1 < hi2) ? hi1 : hi2);
    endfunction

    function automatic bit lex_less(longint px, longint py, longint qx, longint qy);
        return (px < qx) || (px == qx && py < qy);
    endfunction

    function automatic hit_rec_t intersect_segments(seg_pair_t s);
        hit_rec_t h;
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint rx, ry, sx, sy, qx, qy, den, tn, un;
        longint hx, hy, ux, uy, px, py, dt, len2, rem, off;
        ax = longint'(s.ax); ay = longint'(s.ay);
        bx = longint'(s.bx); by = longint'(s.by);
        cx = longint'(s.cx); cy = longint'(s.cy);
        dx = longint'(s.dx); dy = longint'(s.dy);
        h.cls = CLS_NONE;
        h.px  = '0;
        h.py  = '0;
        h.off = '0;
        if (!spans_meet(ax, bx, cx, dx) || !spans_meet(ay, by, cy, dy))
            return h;
        if ((ax == bx && ay == by) || (cx == dx && cy == dy))
        begin
            h.cls = CLS_DEGEN;
            return h;
        end
        rx = bx - ax; ry = by - ay;
        sx = dx - cx; sy = dy - cy;
        qx = cx - ax; qy = cy - ay;
        den = rx * sy - ry * sx;
        if (den == 0)
        begin
            if (qx * ry - qy * rx != 0)
                return h;
            hx = bx; hy = by;
            if (lex_less(bx, by, ax, ay))
            begin
                hx = ax; hy = ay;
            end
            ux = dx; uy = dy;
            if (lex_less(dx, dy, cx, cy))
            begin
                ux = cx; uy = cy;
            end
            px = hx; py = hy;
            if (lex_less(ux, uy, hx, hy))
            begin
                px = ux; py = uy;
            end
            dt   = (px - ax) * rx + (py - ay) * ry;
            len2 = rx * rx + ry * ry;
            off  = floor_div(dt * (64'sd1 <<< OFFSET_BITS), len2, rem);
            if (off < 0) off = 0;
            if (off > (64'sd1 <<< OFFSET_BITS)) off = 64'sd1 <<< OFFSET_BITS;
            h.cls = CLS_OVERLAP;
            h.px  = clamp32(px * (64'sd1 <<< FRAC_BITS));
            h.py  = clamp32(py * (64'sd1 <<< FRAC_BITS));
            h.off = off[OFF_W-1:0];
            return h;
        end
        tn = qx * sy - qy * sx;
        un = qx * ry - qy * rx;
        if (den < 0)
        begin
            den = -den; tn = -tn; un = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den)
            return h;
        off   = floor_div(tn * (64'sd1 <<< OFFSET_BITS), den, rem);
        h.cls = CLS_CROSS;
        h.px  = lerp_point(ax, rx, tn, den);
        h.py  = lerp_point(ay, ry, tn, den);
        h.off = off[OFF_W-1:0];
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic seg_pair_t mk_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        seg_pair_t s;
        s.ax = coord_t'(ax); s.ay = coord_t'(ay);
        s.bx = coord_t'(bx); s.by = coord_t'(by);
        s.cx = coord_t'(cx); s.cy = coord_t'(cy);
        s.dx = coord_t'(dx); s.dy = coord_t'(dy);
        return s;
    endfunction

    function automatic hit_rec_t mk_hit(hit_class_t c, int px, int py, int off);
        hit_rec_t h;
        h.cls = c;
        h.px  = px;
        h.py  = py;
        h.off = OFF_W'(off);
        return h;
    endfunction

    // Append a directed row to the stimulus table.
    function automatic void add_row(seg_pair_t p, bit typed, hit_rec_t want);
        dir_row_t r;
        r.pair  = p;
        r.typed = typed;
        r.want  = want;
        table_rows.insert(table_rows.size(), r);
    endfunction

    // Record the prediction for an accepted request, oldest first.
    function automatic void log_request(hit_rec_t pred, hit_rec_t want, bit typed);
        pending_hits.insert(pending_hits.size(), pred);
        typed_hits.insert(typed_hits.size(), want);
        typed_flags.insert(typed_flags.size(), typed);
    endfunction

    function automatic coord_t rand_coord(int span);
        int v;
        if (span == 0)
            return coord_t'($urandom);
        v = $urandom_range(0, 2 * span);
        return coord_t'(v - span);
    endfunction

    // Random pair, shaped so that most pairs have boxes that meet.
    function automatic seg_pair_t rand_pair();
        seg_pair_t s;
        int kind, span, k, m;
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 14));
        s.ax = rand_coord(span); s.ay = rand_coord(span);
        s.bx = rand_coord(span); s.by = rand_coord(span);
        s.cx = rand_coord(span); s.cy = rand_coord(span);
        s.dx = rand_coord(span); s.dy = rand_coord(span);
        if (kind < 12)
        begin
            // collinear: C and D on the line through A with a small step
            k = $urandom_range(0, 20) - 10;
            m = $urandom_range(0, 20) - 10;
            s.bx = coord_t'(s.ax + 3 * k);
            s.by = coord_t'(s.ay + 3 * m);
            s.cx = coord_t'(s.ax + k * ($urandom_range(0, 6) - 2));
            s.cy = coord_t'(s.ay + m * ((s.cx - s.ax) / ((k == 0) ? 1 : k)));
            if (k == 0)
                s.cy = coord_t'(s.ay + m * ($urandom_range(0, 6) - 2));
            s.dx = coord_t'(s.cx + k * ($urandom_range(0, 6) - 2));
            s.dy = coord_t'(s.cy + ((k == 0) ? m * ($urandom_range(0, 6) - 2)
                                             : m * ((s.dx - s.cx) / k)));
        end
        else if (kind < 20)
        begin
            // parallel, shifted
            s.dx = coord_t'(s.cx + (s.bx - s.ax));
            s.dy = coord_t'(s.cy + (s.by - s.ay));
        end
        else if (kind < 26)
        begin
            // degenerate
            if (kind[0])
            begin
                s.bx = s.ax; s.by = s.ay;
            end
            else
            begin
                s.dx = s.cx; s.dy = s.cy;
            end
        end
        else if (kind < 32)
        begin
            // C on A or on AB end: exercises t and u at the ends
            s.cx = kind[0] ? s.ax : s.bx;
            s.cy = kind[0] ? s.ay : s.by;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present at the falling edge, acceptance seen at rising edge.
    // ------------------------------------------------------------------
    task automatic send_pair(seg_pair_t s, bit typed, hit_rec_t want);
        hit_rec_t pred;
        // random idle before offering, unless in the quiet stretch
        while (!quiet_phase && $urandom_range(0, 99) < 36)
        begin
            pair_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.a_x <= s.ax; pair_ch.a_y <= s.ay;
        pair_ch.b_x <= s.bx; pair_ch.b_y <= s.by;
        pair_ch.c_x <= s.cx; pair_ch.c_y <= s.cy;
        pair_ch.d_x <= s.dx; pair_ch.d_y <= s.dy;
        // hold the request until the block takes it
        do
            @(posedge clk);
        while (!pair_ch.ready);
        pred = intersect_segments(s);
        log_request(pred, want, typed);
        @(negedge clk);
        // valid stays high if the next request follows at once; drop it
        // here only when the next call idles (handled at its top)
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready changes at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            hit_ch.ready <= 1'b0;
        else if (quiet_phase)
            hit_ch.ready <= 1'b1;
        else
            hit_ch.ready <= ($urandom_range(0, 99) >= 36);
    end

    // Compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        hit_rec_t exp_hit, typed_hit;
        bit typed;
        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result class=%0d x=%0d y=%0d off=%0d",
                         $time, hit_ch.hit_class, hit_ch.point_x,
                         hit_ch.point_y, hit_ch.offset_along);
                mismatches++;
            end
            else
            begin
                exp_hit   = pending_hits.pop_front();
                typed_hit = typed_hits.pop_front();
                typed     = typed_flags.pop_front();
                // directed rows with a typed-in result must agree with it too
                if (typed && typed_hit != exp_hit)
                begin
                    $display("%0t: table row disagrees with prediction: class %0d vs %0d",
                             $time, typed_hit.cls, exp_hit.cls);
                    mismatches++;
                end
                if (hit_ch.hit_class !== exp_hit.cls)
                begin
                    $display("%0t: hit_class expected %0d actual %0d",
                             $time, exp_hit.cls, hit_ch.hit_class);
                    mismatches++;
                end
                if (hit_ch.point_x !== exp_hit.px)
                begin
                    $display("%0t: point_x expected %0d actual %0d",
                             $time, exp_hit.px, hit_ch.point_x);
                    mismatches++;
                end
                if (hit_ch.point_y !== exp_hit.py)
                begin
                    $display("%0t: point_y expected %0d actual %0d",
                             $time, exp_hit.py, hit_ch.point_y);
                    mismatches++;
                end
                if (hit_ch.offset_along !== exp_hit.off)
                begin
                    $display("%0t: offset_along expected %0d actual %0d",
                             $time, exp_hit.off, hit_ch.offset_along);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request and no result moving.
    always @(posedge clk)
    begin
        if ((pair_ch.valid && pair_ch.ready) || (hit_ch.valid && hit_ch.ready)
            || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver stall in its own process; the sender keeps offering
    // so the pipeline fills and backpressures the request channel.
    initial
    begin
        hold_off = 1'b0;
        wait (sending_done == 1'b0 && rst_n);
        repeat (300) @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        hit_rec_t none_hit;
        seg_pair_t s;
        int settle;

        mismatches   = 0;
        idle_count   = 0;
        sending_done = 1'b0;
        quiet_phase  = 1'b0;
        none_hit     = mk_hit(CLS_NONE, 0, 0, 0);

        rst_n         = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.a_x = '0; pair_ch.a_y = '0; pair_ch.b_x = '0; pair_ch.b_y = '0;
        pair_ch.c_x = '0; pair_ch.c_y = '0; pair_ch.d_x = '0; pair_ch.d_y = '0;
        hit_ch.ready  = 1'b0;

        // Directed table: boxes apart, degenerate, simple crossings,
        // collinear overlaps, parallel lines, and the coordinate extremes.
        add_row(mk_pair(0, 0, 1, 1, 5, 5, 6, 6), 1'b1, none_hit);
        add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_hit(CLS_DEGEN, 0, 0, 0));
        add_row(mk_pair(0, 0, 4, 4, 1, 1, 1, 1), 1'b1, mk_hit(CLS_DEGEN, 0, 0, 0));
        add_row(mk_pair(9, 9, 9, 9, 0, 0, 1, 1), 1'b1, none_hit);
        add_row(mk_pair(0, 0, 2, 2, 0, 2, 2, 0), 1'b1,
                mk_hit(CLS_CROSS, 32'h10000, 32'h10000, 32'h8000));
        add_row(mk_pair(0, 0, 4, 0, 0, 0, 0, 4), 1'b1, mk_hit(CLS_CROSS, 0, 0, 0));
        add_row(mk_pair(0, 0, 4, 0, 4, 0, 4, 4), 1'b1,
                mk_hit(CLS_CROSS, 32'h40000, 0, 32'h10000));
        add_row(mk_pair(0, 0, 3, 0, 1, -1, 2, 2), 1'b0, none_hit);
        add_row(mk_pair(0, 0, 4, 0, 2, 0, 6, 0), 1'b1,
                mk_hit(CLS_OVERLAP, 32'h40000, 0, 32'h10000));
        add_row(mk_pair(4, 0, 0, 0, 1, 0, 2, 0), 1'b0, none_hit);
        add_row(mk_pair(0, 0, 0, 4, 0, 1, 0, 9), 1'b0, none_hit);
        add_row(mk_pair(0, 0, 4, 0, 0, 1, 4, 1), 1'b0, none_hit);
        add_row(mk_pair(0, 0, 4, 4, 0, 1, 4, 5), 1'b0, none_hit);
        add_row(mk_pair(0, 0, 4, 4, 3, 0, 4, 0), 1'b0, none_hit);
        add_row(mk_pair(-32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768), 1'b0, none_hit);
        add_row(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b0, none_hit);
        add_row(mk_pair(-32768, -32768, 32767, 32767,
                        -32768, -32768, 32767, 32767), 1'b0, none_hit);
        add_row(mk_pair(32767, 32767, -32768, -32768, 0, 0, 1, 2), 1'b0, none_hit);
        add_row(mk_pair(-32768, -32768, -32768, -32768,
                        -32768, -32768, -32767, -32767), 1'b1,
                mk_hit(CLS_DEGEN, 0, 0, 0));
        add_row(mk_pair(0, 0, 3, 1, 0, 1, 3, 0), 1'b0, none_hit);
        add_row(mk_pair(-5, 7, 11, -3, -2, -9, 4, 13), 1'b0, none_hit);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_pair(table_rows[i].pair, table_rows[i].typed, table_rows[i].want);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            // a stretch with no idling on either side
            quiet_phase = (n >= 600 && n < 750);
            s = rand_pair();
            send_pair(s, 1'b0, none_hit);
        end
        quiet_phase   = 1'b0;
        pair_ch.valid <= 1'b0;
        sending_done  = 1'b1;

        settle = 0;
        while (pending_hits.size() != 0 && settle < 100000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && pending_hits.size() == 0 && !hit_ch.valid)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/sid_pkg.sv
sv/sid_pair_if.sv
sv/sid_hit_if.sv
sv/sid_front.sv
sv/sid_div.sv
sv/sid_back.sv
sv/segment_intersection_2d.sv
sv/sid_checker.sv
tb/sv/segment_intersection_2d_test.sv
